// ----- rtl/lkt_pkg.sv -----
// Shared types and constants for the LRU key tracker.
// No dependencies; used by lkt_cell and lru_key_tracker.
package lkt_pkg;

	localparam int KEY_PORT_W      = 64;
	localparam int LEN_W           = 4;
	localparam int TIME_W          = 32;
	localparam int RANK_W          = 5;
	localparam int CAP_W           = 6;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 3;
	localparam int MAX_ENTRIES_DEF = 32;
	localparam int KEY_BYTES_DEF   = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// word index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic cmp_en;  // latch the compare result for the item being accepted
		logic load;    // take the neighbor's entry
	} cell_ctrl_t;

endpackage

// ----- rtl/lru_key_tracker.sv -----
// LRU key tracker: a row of lkt_cell slots in recency order, slot 0 newest.
// The cells latch their compare results when an item is accepted; the update state
// then shifts the cell row and loads the output register, waiting while the output
// register is still held. No new item is accepted until that update is done.
// Reset: all slots invalid, count zero, capacity 32; no clearing pass.
// Depends on lkt_pkg and lkt_cell.
module lru_key_tracker #(
	parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BYTES   = lkt_pkg::KEY_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lkt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lkt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// input items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lkt_pkg::KEY_PORT_W-1:0] key_bytes,
	input  logic [lkt_pkg::LEN_W-1:0]      key_length,
	input  logic [lkt_pkg::TIME_W-1:0]     now_time,
	// result items
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [lkt_pkg::RANK_W-1:0]     prior_rank,
	output logic [lkt_pkg::TIME_W-1:0]     created_time,
	output logic                           evicted,
	output logic [lkt_pkg::KEY_PORT_W-1:0] evicted_key,
	output logic [lkt_pkg::LEN_W-1:0]      evicted_length
);
	import lkt_pkg::*;

	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	// ---------------- configuration ----------------
	logic [CAP_W-1:0] capacity_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
	assign prdata  = reg_sel ? APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// ---------------- control ----------------
	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             fire;
	logic             out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fire     = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	// only the low bytes covered by the length take part
	logic [KEY_W-1:0] in_key_m;
	always_comb begin
		for (int b = 0; b < KEY_BYTES; b++) begin
			in_key_m[8*b +: 8] = (key_length > LEN_W'(b)) ? key_bytes[8*b +: 8] : 8'h00;
		end
	end

	logic [KEY_W-1:0]  key_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [TIME_W-1:0] now_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= in_key_m;
			len_s1 <= key_length;
			now_s1 <= now_time;
		end
	end

	// ---------------- cell row ----------------
	logic [KEY_W-1:0]  cell_key     [MAX_ENTRIES];
	logic [LEN_W-1:0]  cell_len     [MAX_ENTRIES];
	logic [TIME_W-1:0] cell_created [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_v;
	logic [MAX_ENTRIES-1:0] match_v;
	logic [MAX_ENTRIES-1:0] shift_v;

	logic [MAX_ENTRIES-1:0] first_v;
	logic [MAX_ENTRIES-1:0] last_v;
	logic                   hit_w;
	logic                   evict_w;
	logic [RANK_W-1:0]      rank_w;
	logic [TIME_W-1:0]      hit_created;
	logic [KEY_W-1:0]       ev_key;
	logic [LEN_W-1:0]       ev_len;
	logic [TIME_W-1:0]      new_created;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       cap_eff;
	logic [CMP_W-1:0]       max_c;

	assign first_v = match_v & (~match_v + 1'b1);
	assign last_v  = valid_v & ~(valid_v >> 1);
	assign hit_w   = |match_v;

	assign cap_ext = CMP_W'(capacity_q);
	assign max_c   = CMP_W'(MAX_ENTRIES);
	assign cap_eff = (cap_ext == '0) ? CMP_W'(1) : ((cap_ext > max_c) ? max_c : cap_ext);
	assign evict_w = !hit_w && (count_q != '0) && (CMP_W'(count_q) >= cap_eff);

	always_comb begin
		rank_w      = '0;
		hit_created = '0;
		ev_key      = '0;
		ev_len      = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank_w      = rank_w | (first_v[i] ? RANK_W'(i) : '0);
			hit_created = hit_created | (first_v[i] ? cell_created[i] : '0);
			ev_key      = ev_key | (last_v[i] ? cell_key[i] : '0);
			ev_len      = ev_len | (last_v[i] ? cell_len[i] : '0);
		end
	end

	// hit: slots up to the match shift; miss: slots up to the new count shift
	always_comb begin
		if (hit_w) begin
			shift_v = first_v | (first_v - 1'b1);
		end else if (evict_w) begin
			shift_v = valid_v;
		end else begin
			shift_v = {valid_v[MAX_ENTRIES-2:0], 1'b1};
		end
	end

	assign new_created = hit_w ? hit_created : now_s1;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [KEY_W-1:0]  p_key;
		logic [LEN_W-1:0]  p_len;
		logic [TIME_W-1:0] p_created;
		logic              p_valid;

		assign ctrl.cmp_en = accept;
		assign ctrl.load   = fire && shift_v[g];

		if (g == 0) begin : g_head
			assign p_key     = key_s1;
			assign p_len     = len_s1;
			assign p_created = new_created;
			assign p_valid   = 1'b1;
		end else begin : g_body
			assign p_key     = cell_key[g-1];
			assign p_len     = cell_len[g-1];
			assign p_created = cell_created[g-1];
			assign p_valid   = valid_v[g-1];
		end

		lkt_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cmp_key     (in_key_m),
			.cmp_len     (key_length),
			.prev_key    (p_key),
			.prev_len    (p_len),
			.prev_created(p_created),
			.prev_valid  (p_valid),
			.key         (cell_key[g]),
			.len         (cell_len[g]),
			.created     (cell_created[g]),
			.valid       (valid_v[g]),
			.match       (match_v[g])
		);
	end

	// ---------------- state, count, output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire && !hit_w && !evict_w) begin
				count_q <= count_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic                  hit_q;
	logic [RANK_W-1:0]     rank_q;
	logic [TIME_W-1:0]     created_q;
	logic                  evicted_q;
	logic [KEY_PORT_W-1:0] ev_key_q;
	logic [LEN_W-1:0]      ev_len_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q     <= hit_w;
			rank_q    <= hit_w ? rank_w : '0;
			created_q <= new_created;
			evicted_q <= evict_w;
			ev_key_q  <= evict_w ? KEY_PORT_W'(ev_key) : '0;
			ev_len_q  <= evict_w ? ev_len : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign prior_rank     = rank_q;
	assign created_time   = created_q;
	assign evicted        = evicted_q;
	assign evicted_key    = ev_key_q;
	assign evicted_length = ev_len_q;

	// ---------------- assertions ----------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above row length");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(count_q))
		else $error("valid slots disagree with entry count");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_v[0] && out_valid_q)
		else $error("update left head slot empty or no result");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_q |-> !hit_q)
		else $error("eviction reported on a hit");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("accepted a second item while one is in flight");

endmodule

// ----- rtl/lkt_cell.sv -----
// One recency slot of the tracker: holds an entry, compares it with the
// broadcast key and loads its newer neighbor's entry on a shift. Uses lkt_pkg.
module lkt_cell #(
	parameter int KEY_W = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkt_pkg::cell_ctrl_t        ctrl,
	input  logic [KEY_W-1:0]           cmp_key,
	input  logic [lkt_pkg::LEN_W-1:0]  cmp_len,
	input  logic [KEY_W-1:0]           prev_key,
	input  logic [lkt_pkg::LEN_W-1:0]  prev_len,
	input  logic [lkt_pkg::TIME_W-1:0] prev_created,
	input  logic                       prev_valid,
	output logic [KEY_W-1:0]           key,
	output logic [lkt_pkg::LEN_W-1:0]  len,
	output logic [lkt_pkg::TIME_W-1:0] created,
	output logic                       valid,
	output logic                       match
);
	import lkt_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [TIME_W-1:0] created_q;
	logic              valid_q;
	logic              match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				valid_q <= prev_valid;
			end
			if (ctrl.cmp_en) begin
				match_q <= valid_q && (len_q == cmp_len) && (key_q == cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q     <= prev_key;
			len_q     <= prev_len;
			created_q <= prev_created;
		end
	end

	assign key     = key_q;
	assign len     = len_q;
	assign created = created_q;
	assign valid   = valid_q;
	assign match   = match_q;

endmodule
